### rtl/core/sorted_multi_timer_bank_assert.svh
// Assertion macros for the sorted timer bank.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef SORTED_MULTI_TIMER_BANK_ASSERT_SVH
`define SORTED_MULTI_TIMER_BANK_ASSERT_SVH

// checked outside reset only
`define SMTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SMTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/smtb_pkg.sv
// Shared types and codes for the sorted timer bank.
// No dependencies; imported by smtb_cell and sorted_multi_timer_bank.
package smtb_pkg;

  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_QUERY  = 2'd3
  } smtb_cmd_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID_ID  = 2'd1;
  localparam logic [1:0] ST_ALREADY_ARM = 2'd2;
  localparam logic [1:0] ST_NOT_ARMED   = 2'd3;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // one slot of the sorted expiry list
  typedef struct packed {
    logic        vld;
    logic [5:0]  id;
    logic [63:0] exp;
  } smtb_ent_t;

  // list operation broadcast to every cell
  typedef struct packed {
    logic        ins;
    logic        rem;
    logic        pop;
    logic [5:0]  id;
    logic [63:0] exp;
  } smtb_op_t;

endpackage

### rtl/core/sorted_multi_timer_bank.sv
// Top level of the sorted timer bank: command sequencer, count memory, output word.
// Depends on smtb_pkg, smtb_cell and sorted_multi_timer_bank_assert.svh.

// A bank of BANK_SIZE one-shot timers whose armed entries sit in a row of list
// cells kept sorted by expiry time. A set, cancel or query passes through S_CMD and
// S_APPLY, where its reply is loaded into the output register once that is free, and
// the input is ready again on the return to S_IDLE. A tick passes through S_FIRE and
// then, for each firing timer (up to 16), through S_CNT and back, since each firing
// pops the head cell and goes through the expiry count memory, which has one read and
// one write port. The input is held off while a command is in progress or while a
// result waits for a full output register; there is no clearing pass after reset.
module sorted_multi_timer_bank
  import smtb_pkg::*;
#(
  parameter int BANK_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: timers_in_use
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] timer_id, [37:6] timeout, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [5:0] result_timer, [7:6] status, [8] armed,
                                  // [24:9] expiry_count, [31:25] zero
  output logic        out_tuser,  // [0] result_kind
  output logic        out_tlast
);

  localparam int IDW = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
  localparam logic [6:0] NT = 7'(BANK_SIZE);
  localparam logic [4:0] MAXR = 5'(MAX_RESULTS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMD   = 5'b00010,
    S_APPLY = 5'b00100,
    S_FIRE  = 5'b01000,
    S_CNT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]  tiu_r;
  logic [63:0] time_r;
  smtb_cmd_t   cmd_r;
  logic [5:0]  cmd_id_r;
  logic [31:0] tmo_r;
  logic [63:0] exp_sum_r;
  logic        id_ok_r;
  logic [5:0]  fire_id_r;
  logic [4:0]  fire_n_r;

  logic [BANK_SIZE-1:0] arm_r;
  logic [BANK_SIZE-1:0] cnt_vld_r;
  logic [15:0]          cnt_mem [BANK_SIZE];
  logic [15:0]          rd_data_r;
  logic                 rd_vld_r;

  logic [31:0] out_tdata_r;
  logic        out_tuser_r, out_tlast_r, out_tvalid_r;

  // list chain
  smtb_op_t             op;
  smtb_ent_t            ent_w [BANK_SIZE+1];
  logic [BANK_SIZE-1:0] ge_w, match_w, after_w, ent_vld;

  logic            in_acc, out_free, id_ok, fire_ok, load;
  logic [IDW-1:0]  cmd_idx, head_idx, rd_addr;
  logic            cmd_arm;
  logic [15:0]     cnt_val, cnt_inc;
  logic [1:0]      st;
  logic            arm_after;
  logic            cnt_we;
  logic [31:0]     load_data;
  logic            load_user, load_last;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign cmd_idx  = cmd_id_r[IDW-1:0];
  assign head_idx = ent_w[0].id[IDW-1:0];
  assign cmd_arm  = id_ok_r && arm_r[cmd_idx];
  assign cnt_val  = rd_vld_r ? rd_data_r : 16'd0;
  assign cnt_inc  = (cnt_val == 16'hFFFF) ? cnt_val : cnt_val + 16'd1;

  // id below min(timers_in_use, BANK_SIZE)
  assign id_ok = ({1'b0, cmd_id_r} < {2'b00, tiu_r}) && ({1'b0, cmd_id_r} < NT);

  // head due against the already advanced time, within the per-tick budget
  assign fire_ok = ent_w[0].vld && (ent_w[0].exp <= time_r) && (fire_n_r < MAXR);

  // keep the fired timer's count on the read port while its word waits
  assign rd_addr = (state_r == S_FIRE) ? head_idx :
                   (state_r == S_CNT)  ? fire_id_r[IDW-1:0] : cmd_idx;

  // status and armed flag of a command reply
  always_comb begin
    st        = ST_OK;
    arm_after = cmd_arm;
    if (!id_ok_r) begin
      st        = ST_INVALID_ID;
      arm_after = 1'b0;
    end else begin
      case (cmd_r)
        CMD_SET: begin
          if (cmd_arm) st = ST_ALREADY_ARM;
          arm_after = 1'b1;
        end
        CMD_CANCEL: begin
          if (!cmd_arm) st = ST_NOT_ARMED;
          arm_after = 1'b0;
        end
        default: begin
          arm_after = cmd_arm;
        end
      endcase
    end
  end

  always_comb begin
    op.ins = (state_r == S_APPLY) && out_free && id_ok_r && (cmd_r == CMD_SET) && !cmd_arm;
    op.rem = (state_r == S_APPLY) && out_free && id_ok_r && (cmd_r == CMD_CANCEL) && cmd_arm;
    op.pop = (state_r == S_FIRE) && fire_ok;
    op.id  = cmd_id_r;
    op.exp = exp_sum_r;
  end

  assign ent_w[BANK_SIZE] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < BANK_SIZE; gi++) begin : g_cell
      smtb_ent_t prev_ent;
      logic      prev_ge;
      if (gi == 0) begin : g_head
        assign prev_ent = '0;
        assign prev_ge  = 1'b0;
      end else begin : g_body
        assign prev_ent = ent_w[gi-1];
        assign prev_ge  = ge_w[gi-1];
      end
      assign after_w[gi] = |match_w[gi:0];
      assign ent_vld[gi] = ent_w[gi].vld;

      smtb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .prev_ent (prev_ent),
        .next_ent (ent_w[gi+1]),
        .prev_ge  (prev_ge),
        .after    (after_w[gi]),
        .ent      (ent_w[gi]),
        .ge       (ge_w[gi]),
        .match    (match_w[gi])
      );
    end
  endgenerate

  // sequencer
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    load_user = KIND_REPLY;
    load_last = 1'b1;
    load_data = {7'd0, cnt_val, arm_after, st, cmd_id_r};
    cnt_we    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (smtb_cmd_t'(in_tuser) == CMD_TICK) ? S_FIRE : S_CMD;
        end
      end
      S_CMD: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (!id_ok_r) load_data = {7'd0, 16'd0, 1'b0, st, cmd_id_r};
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIRE: begin
        state_nxt = fire_ok ? S_CNT : S_IDLE;
      end
      S_CNT: begin
        load_user = KIND_EXPIRY;
        load_last = !fire_ok;   // look ahead at the new head
        load_data = {7'd0, cnt_inc, 1'b0, ST_OK, fire_id_r};
        if (out_free) begin
          load      = 1'b1;
          cnt_we    = 1'b1;
          state_nxt = fire_ok ? S_FIRE : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tiu_r        <= 5'd16;
      time_r       <= 64'd0;
      arm_r        <= '0;
      cnt_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
      fire_n_r     <= 5'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) tiu_r <= cfg_data;
      if (in_acc && (smtb_cmd_t'(in_tuser) == CMD_TICK)) begin
        time_r   <= time_r + 64'd1;
        fire_n_r <= 5'd0;
      end
      if (op.pop) begin
        fire_n_r           <= fire_n_r + 5'd1;
        arm_r[head_idx]    <= 1'b0;
      end
      if (op.ins) arm_r[cmd_idx] <= 1'b1;
      if (op.rem) arm_r[cmd_idx] <= 1'b0;
      if (cnt_we) cnt_vld_r[fire_id_r[IDW-1:0]] <= 1'b1;
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= smtb_cmd_t'(in_tuser);
      cmd_id_r <= in_tdata[5:0];
      tmo_r    <= in_tdata[37:6];
    end
    if (state_r == S_CMD) begin
      exp_sum_r <= time_r + {32'd0, tmo_r};
      id_ok_r   <= id_ok;
    end
    if (op.pop) fire_id_r <= ent_w[0].id;
    if (load) begin
      out_tdata_r <= load_data;
      out_tuser_r <= load_user;
      out_tlast_r <= load_last;
    end
  end

  // expiry count memory, one port each way
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[fire_id_r[IDW-1:0]] <= cnt_inc;
    rd_data_r <= cnt_mem[rd_addr];
    rd_vld_r  <= cnt_vld_r[rd_addr];
  end

`include "sorted_multi_timer_bank_assert.svh"

  `SMTB_ASSERT(a_list_packed, !ent_vld[0] |-> (ent_vld == '0), "hole at list head")
  `SMTB_ASSERT(a_list_armed, $countones(ent_vld) == $countones(arm_r), "list and armed flags disagree")
  `SMTB_ASSERT(a_cnt_from_fire, (state_r == S_CNT) |-> ($past(state_r) == S_FIRE || $past(state_r) == S_CNT), "count step without a firing")
  `SMTB_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

### rtl/core/smtb_cell.sv
// One slot of the sorted expiry list: holds an entry, shifts with its neighbours.
// Depends on smtb_pkg.
module smtb_cell
  import smtb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  smtb_op_t  op,
  input  smtb_ent_t prev_ent,
  input  smtb_ent_t next_ent,
  input  logic      prev_ge,   // predecessor is at or behind the insert point
  input  logic      after,     // removal match at or before this slot
  output smtb_ent_t ent,
  output logic      ge,
  output logic      match
);

  logic        vld_r, vld_nxt;
  logic [5:0]  id_r, id_nxt;
  logic [63:0] exp_r, exp_nxt;

  assign ent   = '{vld: vld_r, id: id_r, exp: exp_r};
  // ties: new entry goes ahead of equal expiries
  assign ge    = !vld_r || (op.exp <= exp_r);
  assign match = vld_r && (id_r == op.id);

  always_comb begin
    vld_nxt = vld_r;
    id_nxt  = id_r;
    exp_nxt = exp_r;
    if (op.ins) begin
      if (prev_ge) begin
        vld_nxt = prev_ent.vld;
        id_nxt  = prev_ent.id;
        exp_nxt = prev_ent.exp;
      end else if (ge) begin
        vld_nxt = 1'b1;
        id_nxt  = op.id;
        exp_nxt = op.exp;
      end
    end else if (op.pop || (op.rem && after)) begin
      vld_nxt = next_ent.vld;
      id_nxt  = next_ent.id;
      exp_nxt = next_ent.exp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    exp_r <= exp_nxt;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_multi_timer_bank: drives timer commands and limit
// writes, predicts every reply and expiry word in a scoreboard class and compares them.
// Depends on smtb_pkg and the block's RTL.
module tb_top;
  import smtb_pkg::*;

  localparam int N_TIMERS    = 16;
  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE      = 8;
  localparam int TAIL_CYCLES = 60;
  localparam int LONG_STALL  = 400;
  localparam int RAND_PHASES = 4;
  localparam int PHASE_ITEMS = 83;

  typedef struct packed {
    logic        kind;
    logic [5:0]  timer;
    logic [1:0]  status;
    logic        armed;
    logic [15:0] count;
    logic        last;
  } timer_word_t;

  class timer_bank_scoreboard;
    logic [4:0]  in_use;
    logic [63:0] now_tick;
    logic [63:0] due_tick [N_TIMERS];
    logic        is_armed [N_TIMERS];
    logic [15:0] fired    [N_TIMERS];
    int          due_order[$];   // armed timer ids, earliest expiry first
    timer_word_t awaited[$];
    int          errors, commands, replies, expiries, writes;

    function new();
      in_use   = 5'd16;
      now_tick = '0;
      foreach (due_tick[i]) begin
        due_tick[i] = '0;
        is_armed[i] = 1'b0;
        fired[i]    = '0;
      end
      errors   = 0;
      commands = 0;
      replies  = 0;
      expiries = 0;
      writes   = 0;
    endfunction

    function void set_limit(logic [4:0] value);
      in_use = value;
      writes++;
    endfunction

    function void await_word(logic kind, logic [5:0] id, logic [1:0] st, logic arm,
                             logic [15:0] cnt, logic lst);
      timer_word_t w;
      w.kind   = kind;
      w.timer  = id;
      w.status = st;
      w.armed  = arm;
      w.count  = cnt;
      w.last   = lst;
      awaited.push_back(w);
    endfunction

    function void note_command(smtb_cmd_t cmd, logic [5:0] id, logic [31:0] tmo);
      int unsigned usable;
      int          fired_now;
      int          t;
      int          pos;
      logic        more;
      logic [1:0]  st;
      commands++;
      usable = (in_use < N_TIMERS) ? in_use : N_TIMERS;
      if (cmd == CMD_TICK) begin
        now_tick++;
        fired_now = 0;
        more = due_order.size() > 0 && due_tick[due_order[0]] <= now_tick;
        while (more) begin
          t = due_order.pop_front();
          is_armed[t] = 1'b0;
          if (fired[t] != 16'hFFFF) fired[t]++;
          fired_now++;
          more = fired_now < MAX_RESULTS && due_order.size() > 0 &&
                 due_tick[due_order[0]] <= now_tick;
          await_word(KIND_EXPIRY, t[5:0], ST_OK, 1'b0, fired[t], !more);
        end
        return;
      end
      if (id >= usable) begin
        await_word(KIND_REPLY, id, ST_INVALID_ID, 1'b0, 16'd0, 1'b1);
        return;
      end
      st  = ST_OK;
      pos = 0;
      case (cmd)
        CMD_SET: begin
          if (is_armed[id]) begin
            st = ST_ALREADY_ARM;
          end else begin
            is_armed[id] = 1'b1;
            due_tick[id] = now_tick + tmo;
            // a new entry goes ahead of equal expiries
            while (pos < due_order.size() && due_tick[due_order[pos]] < due_tick[id]) pos++;
            due_order.insert(pos, id);
          end
        end
        CMD_CANCEL: begin
          if (!is_armed[id]) begin
            st = ST_NOT_ARMED;
          end else begin
            is_armed[id] = 1'b0;
            foreach (due_order[i]) if (due_order[i] == id) pos = i;
            due_order.delete(pos);
          end
        end
        default: ;
      endcase
      await_word(KIND_REPLY, id, st, is_armed[id], fired[id], 1'b1);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic kind, logic [31:0] data, logic lst);
      timer_word_t w;
      if (awaited.size() == 0) begin
        $error("result word with nothing expected: kind %0d timer %0d", kind, data[5:0]);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (w.kind == KIND_EXPIRY) expiries++;
      else replies++;
      compare("result_kind", w.kind, kind);
      compare("result_timer", w.timer, data[5:0]);
      compare("status", w.status, data[7:6]);
      compare("armed", w.armed, data[8]);
      compare("expiry_count", w.count, data[24:9]);
      compare("last", w.last, lst);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [5:0] timer_id, [37:6] timeout, [39:38] zero
  logic [1:0]  in_tuser = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [5:0] result_timer, [7:6] status, [8] armed,
                                // [24:9] expiry_count, [31:25] zero
  logic        out_tuser;       // [0] result_kind
  logic        out_tlast;

  int stall_request = 0;
  int cycle_count = 0;
  timer_bank_scoreboard board = new();

  sorted_multi_timer_bank #(.BANK_SIZE(N_TIMERS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // result words are checked before the accepted input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_word(out_tuser, out_tdata, out_tlast);
      if (in_tvalid && in_tready)
        board.note_command(smtb_cmd_t'(in_tuser), in_tdata[5:0], in_tdata[37:6]);
      if (cfg_valid && cfg_ready) board.set_limit(cfg_data);
    end
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic send_word(smtb_cmd_t cmd, logic [5:0] id, logic [31:0] tmo);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, tmo, id};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // one edge first so the last accepted word is already in the scoreboard
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (stall_request > 0) begin
        gap = stall_request;
        stall_request = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  initial begin : stimulus
    int          usable;
    int          left;
    int          k;
    logic [5:0]  rid;
    logic [31:0] rtmo;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_QUERY, 6'd0, 32'd0);
    send_word(CMD_CANCEL, 6'd3, 32'd0);           // idle timer: not armed
    send_word(CMD_SET, 6'd63, 32'hFFFF_FFFF);     // ids past the bank
    send_word(CMD_SET, 6'd16, 32'd5);
    send_word(CMD_TICK, 6'd42, 32'h5555_AAAA);    // nothing due, no word back
    send_word(CMD_SET, 6'd5, 32'd0);              // due on the very next tick
    send_word(CMD_SET, 6'd5, 32'd7);              // already armed, old expiry kept
    send_word(CMD_SET, 6'd2, 32'd3);
    send_word(CMD_SET, 6'd7, 32'd3);              // tie: lands ahead of timer 2
    send_word(CMD_SET, 6'd15, 32'hFFFF_FFFF);
    send_word(CMD_SET, 6'd9, 32'h8000_0000);
    send_word(CMD_QUERY, 6'd5, 32'd0);
    send_word(CMD_TICK, 6'd0, 32'd0);
    send_word(CMD_CANCEL, 6'd9, 32'd0);
    send_word(CMD_QUERY, 6'd9, 32'd0);
    send_word(CMD_CANCEL, 6'd15, 32'd0);
    repeat (3) send_word(CMD_TICK, 6'd21, 32'hAAAA_5555);
    send_word(CMD_QUERY, 6'd7, 32'd0);
    drain();

    write_limit(5'd0);                            // every id rejected
    send_word(CMD_SET, 6'd0, 32'd1);
    send_word(CMD_QUERY, 6'd0, 32'd0);
    send_word(CMD_TICK, 6'd0, 32'd0);
    drain();

    write_limit(5'd31);                           // behaves as a full bank
    send_word(CMD_SET, 6'd15, 32'd2);
    send_word(CMD_SET, 6'd12, 32'd3);
    send_word(CMD_QUERY, 6'd15, 32'd0);
    drain();

    // timers above the lowered limit stay armed and still fire
    write_limit(5'd4);
    send_word(CMD_QUERY, 6'd15, 32'd0);
    send_word(CMD_CANCEL, 6'd12, 32'd0);
    send_word(CMD_SET, 6'd3, 32'd1);
    send_word(CMD_SET, 6'd4, 32'd1);
    repeat (4) send_word(CMD_TICK, 6'd0, 32'd0);
    drain();

    write_limit(5'd1);
    send_word(CMD_SET, 6'd0, 32'd0);
    send_word(CMD_SET, 6'd1, 32'd0);
    send_word(CMD_TICK, 6'd0, 32'd0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      usable = (p == 0) ? 16 : $urandom_range(1, 16);
      write_limit(usable[4:0]);
      if (p == 1) stall_request = LONG_STALL;
      left = PHASE_ITEMS;
      while (left > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          // arm most of the bank with short timeouts, then tick through them
          for (int id = 0; id < usable; id++) begin
            if ($urandom_range(0, 3) != 0) begin
              send_word(CMD_SET, id[5:0], $urandom_range(0, 6));
              left--;
            end
          end
          k = $urandom_range(1, 8);
          repeat (k) send_word(CMD_TICK, 6'($urandom), $urandom);
          left -= k;
        end else begin
          rid = ($urandom_range(0, 6) == 0) ? 6'($urandom) : 6'($urandom_range(0, usable));
          case ($urandom_range(0, 9))
            0, 1:    rtmo = $urandom;
            2:       rtmo = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: rtmo = $urandom_range(0, 20);
          endcase
          k = $urandom_range(0, 9);
          send_word(k < 4 ? CMD_TICK : k < 7 ? CMD_SET : k < 8 ? CMD_CANCEL : CMD_QUERY,
                    rid, rtmo);
          left--;
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d commands, %0d status replies, %0d expiry events, %0d limit writes",
             board.commands, board.replies, board.expiries, board.writes);
    $display("summary: limits 0, 1, 4, 16, 31 and random, full-bank bursts, a long output stall");
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
